// File: hdl/assert_macros.svh
// assert_macros.svh: assertion macros shared by the rtl
// concurrent checks on clk with rst_n low disabling them; empty in synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SNP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define SNP_ASSERT_MSG(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
`else
`define SNP_ASSERT(lbl, prop)
`define SNP_ASSERT_MSG(lbl, prop, msg)
`endif
`endif

// File: hdl/snp_pkg.sv
// snp_pkg: types, character codes and helpers for the sheet notation parser
// no dependencies; used by every module of the block
package snp_pkg;

    localparam int SNP_MAX_CHORD = 16;
    localparam int KEY_W         = 5;
    localparam int NUM_W         = 16;
    localparam int Q_DEPTH       = 2;

    localparam logic [NUM_W-1:0] DEFAULT_DELAY_RST = 16'd100;
    localparam logic [NUM_W-1:0] NUM_SAT           = 16'hFFFF;
    localparam logic [KEY_W-1:0] KEY_MAX           = 5'd25;

    // character codes
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LZ     = 8'h7A;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CASE_GAP  = 8'h20;
    localparam logic [19:0] RADIX    = 20'd10;

    // parser modes
    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_BRACKET = 2'd1;
    localparam logic [1:0] MODE_CHORD   = 2'd2;
    localparam logic [1:0] MODE_DIGITS  = 2'd3;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_sheet;
    } in_item_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [NUM_W-1:0] duration;
        logic             last_of_note;
        logic             chord_truncated;
    } out_item_t;

    // per-note data that travels with the key list
    typedef struct packed {
        logic [NUM_W-1:0] duration;
        logic             truncated;
    } note_info_t;

    // v * 10 + d, saturated to 16 bits
    function automatic logic [NUM_W-1:0] acc_digit(input logic [NUM_W-1:0] v,
                                                   input logic [3:0] d);
        logic [19:0] r;
        r = {4'b0, v} * RADIX + {16'b0, d};
        return (r > {4'b0, NUM_SAT}) ? NUM_SAT : r[NUM_W-1:0];
    endfunction

endpackage

// File: hdl/sheet_notation_parser.sv
// sheet_notation_parser: top level of the music-sheet text parser
// depends on snp_pkg, snp_front, snp_queue, snp_back and assert_macros.svh

// Takes sheet text one byte per item and returns one item per note key, with
// last_of_note on the final key of each note or chord. The parser accepts a
// byte every cycle unless stalled; a byte carrying end_of_sheet also moves it
// to an end-of-sheet state that flushes any open note and restarts the parser.
// Finished notes wait in a two-entry note queue; the emitter drains the head
// note at one key per cycle while note_stall allows. Bytes stall only while
// that queue is full or an end of sheet is flushed. A cfg_we write sets the
// default and current delay, unless a bracket or restart sets the current one.
`include "assert_macros.svh"

module sheet_notation_parser
    import snp_pkg::*;
#(
    parameter int MAX_CHORD = SNP_MAX_CHORD
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             byte_valid,
    output logic             byte_stall,
    input  in_item_t         byte_item,
    output logic             note_valid,
    input  logic             note_stall,
    output out_item_t        note_item,
    input  logic             cfg_we,
    input  logic [NUM_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(MAX_CHORD + 1);

    logic                       q_push;
    logic                       q_full;
    logic                       q_pop;
    logic                       q_head_valid;
    logic [MAX_CHORD*KEY_W-1:0] q_push_keys;
    logic [MAX_CHORD*KEY_W-1:0] q_head_keys;
    logic [CNT_W-1:0]           q_push_count;
    logic [CNT_W-1:0]           q_head_count;
    note_info_t                 q_push_info;
    note_info_t                 q_head_info;

    // parser front
    snp_front #(
        .MAX_CHORD (MAX_CHORD)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .q_full     (q_full),
        .push       (q_push),
        .push_keys  (q_push_keys),
        .push_count (q_push_count),
        .push_info  (q_push_info)
    );

    // note queue
    snp_queue #(
        .MAX_CHORD (MAX_CHORD)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_keys  (q_push_keys),
        .push_count (q_push_count),
        .push_info  (q_push_info),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_keys  (q_head_keys),
        .head_count (q_head_count),
        .head_info  (q_head_info)
    );

    // key emitter
    snp_back #(
        .MAX_CHORD (MAX_CHORD)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_keys  (q_head_keys),
        .head_count (q_head_count),
        .head_info  (q_head_info),
        .pop        (q_pop),
        .note_valid (note_valid),
        .note_stall (note_stall),
        .note_item  (note_item)
    );

    // checks
    `SNP_ASSERT_MSG(a_no_push_when_full, !(q_push && q_full), "note pushed into full queue")
    `SNP_ASSERT_MSG(a_pop_emits_last, q_pop |=> (note_valid && note_item.last_of_note), "pop without last key")
    `SNP_ASSERT(a_key_in_range, note_valid |-> (note_item.key <= KEY_MAX))

endmodule

// File: hdl/snp_front.sv
// snp_front: byte parser; tracks delays, digits and the chord buffer
// depends on snp_pkg; pushes finished notes into snp_queue
module snp_front
    import snp_pkg::*;
#(
    parameter int MAX_CHORD = SNP_MAX_CHORD
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        byte_valid,
    output logic                        byte_stall,
    input  in_item_t                    byte_item,
    input  logic                        cfg_we,
    input  logic [NUM_W-1:0]            cfg_data,
    input  logic                        q_full,
    output logic                        push,
    output logic [MAX_CHORD*KEY_W-1:0]  push_keys,
    output logic [$clog2(MAX_CHORD+1)-1:0] push_count,
    output note_info_t                  push_info
);

    localparam int CNT_W = $clog2(MAX_CHORD + 1);
    localparam int IDX_W = (MAX_CHORD > 1) ? $clog2(MAX_CHORD) : 1;
    localparam logic ST_RUN = 1'b0;
    localparam logic ST_EOS = 1'b1;

    logic             state_reg, state_next;
    logic [1:0]       mode_reg, mode_next;
    logic [NUM_W-1:0] def_reg, def_next;
    logic [NUM_W-1:0] cur_reg, cur_next;
    logic [NUM_W-1:0] brk_reg, brk_next;
    logic [NUM_W-1:0] pend_reg, pend_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [KEY_W-1:0] keys_reg [MAX_CHORD];

    logic             key_we;
    logic [IDX_W-1:0] key_idx;
    logic [KEY_W-1:0] key_val;
    logic             accept;
    logic [7:0]       c;
    logic [3:0]       dval;
    logic             digit;
    logic             letter;
    logic             flush_need;
    logic [1:0]       m;

    assign byte_stall = (state_reg != ST_RUN) || q_full;
    assign accept     = byte_valid && !byte_stall;

    // fold case and classify the byte
    always_comb
    begin
        c = byte_item.char_code;
        if (c >= CH_LA && c <= CH_LZ)
        begin
            c = c - CASE_GAP;
        end
        digit  = (c >= CH_0) && (c <= CH_9);
        letter = (c >= CH_UA) && (c <= CH_UZ);
        dval   = 4'(c - CH_0);
    end

    // note snapshot handed to the queue
    genvar gi;
    generate
        for (gi = 0; gi < MAX_CHORD; gi++)
        begin : g_pack
            assign push_keys[gi*KEY_W +: KEY_W] = keys_reg[gi];
        end
    endgenerate
    assign push_count         = count_reg;
    assign push_info.duration = (pend_reg != '0) ? pend_reg : cur_reg;
    assign push_info.truncated = ovf_reg;

    // parser next state
    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        def_next   = def_reg;
        cur_next   = cur_reg;
        brk_next   = brk_reg;
        pend_next  = pend_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        key_we     = 1'b0;
        key_idx    = '0;
        key_val    = 5'(c - CH_UA);
        push       = 1'b0;
        flush_need = 1'b0;
        m          = mode_reg;

        if (cfg_we)
        begin
            def_next = cfg_data;
            cur_next = cfg_data;
        end

        if (state_reg == ST_RUN)
        begin
            if (accept)
            begin
                if (!byte_item.char_code[7])
                begin
                    // a pending note ends at the first non-digit
                    if (m == MODE_DIGITS)
                    begin
                        if (digit)
                        begin
                            pend_next = acc_digit(pend_reg, dval);
                        end
                        else
                        begin
                            push       = (count_reg != '0);
                            count_next = '0;
                            ovf_next   = 1'b0;
                            pend_next  = '0;
                            m          = MODE_IDLE;
                        end
                    end
                    case (m)
                        MODE_IDLE:
                        begin
                            if (c == CH_LBRACK)
                            begin
                                brk_next = '0;
                                m        = MODE_BRACKET;
                            end
                            else if (c == CH_LPAREN)
                            begin
                                count_next = '0;
                                ovf_next   = 1'b0;
                                pend_next  = '0;
                                m          = MODE_CHORD;
                            end
                            else if (letter)
                            begin
                                key_we     = 1'b1;
                                key_idx    = '0;
                                count_next = CNT_W'(1);
                                ovf_next   = 1'b0;
                                pend_next  = '0;
                                m          = MODE_DIGITS;
                            end
                        end
                        MODE_BRACKET:
                        begin
                            if (c == CH_RBRACK)
                            begin
                                if (brk_reg != '0)
                                begin
                                    cur_next = brk_reg;
                                end
                                m = MODE_IDLE;
                            end
                            else if (digit)
                            begin
                                brk_next = acc_digit(brk_reg, dval);
                            end
                        end
                        MODE_CHORD:
                        begin
                            if (c == CH_RPAREN)
                            begin
                                pend_next = '0;
                                m         = MODE_DIGITS;
                            end
                            else if (letter)
                            begin
                                if (count_reg < CNT_W'(MAX_CHORD))
                                begin
                                    key_we     = 1'b1;
                                    key_idx    = count_reg[IDX_W-1:0];
                                    count_next = count_reg + CNT_W'(1);
                                end
                                else
                                begin
                                    ovf_next = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    mode_next = m;
                end
                if (byte_item.end_of_sheet)
                begin
                    state_next = ST_EOS;
                end
            end
        end
        else
        begin
            // end of sheet: flush what is open, then restart
            flush_need = ((mode_reg == MODE_DIGITS) || (mode_reg == MODE_CHORD))
                         && (count_reg != '0);
            if (!flush_need || !q_full)
            begin
                push       = flush_need;
                state_next = ST_RUN;
                mode_next  = MODE_IDLE;
                cur_next   = def_reg;
                brk_next   = '0;
                pend_next  = '0;
                count_next = '0;
                ovf_next   = 1'b0;
            end
        end
    end

    // control and parser registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            mode_reg  <= MODE_IDLE;
            def_reg   <= DEFAULT_DELAY_RST;
            cur_reg   <= DEFAULT_DELAY_RST;
            brk_reg   <= '0;
            pend_reg  <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            def_reg   <= def_next;
            cur_reg   <= cur_next;
            brk_reg   <= brk_next;
            pend_reg  <= pend_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    // chord key buffer
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            keys_reg[key_idx] <= key_val;
        end
    end

endmodule

// File: hdl/snp_queue.sv
// snp_queue: short fifo of finished notes between parser and emitter
// depends on snp_pkg for widths and the note info type
module snp_queue
    import snp_pkg::*;
#(
    parameter int MAX_CHORD = SNP_MAX_CHORD
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  logic [MAX_CHORD*KEY_W-1:0]     push_keys,
    input  logic [$clog2(MAX_CHORD+1)-1:0] push_count,
    input  note_info_t                     push_info,
    output logic                           full,
    input  logic                           pop,
    output logic                           head_valid,
    output logic [MAX_CHORD*KEY_W-1:0]     head_keys,
    output logic [$clog2(MAX_CHORD+1)-1:0] head_count,
    output note_info_t                     head_info
);

    localparam int CNT_W = $clog2(MAX_CHORD + 1);
    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int LVL_W = $clog2(Q_DEPTH + 1);

    logic [MAX_CHORD*KEY_W-1:0] keys_mem  [Q_DEPTH];
    logic [CNT_W-1:0]           count_mem [Q_DEPTH];
    note_info_t                 info_mem  [Q_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] level_reg, level_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (level_reg == LVL_W'(Q_DEPTH));
    assign head_valid = (level_reg != '0);
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    assign head_keys  = keys_mem[rd_ptr_reg];
    assign head_count = count_mem[rd_ptr_reg];
    assign head_info  = info_mem[rd_ptr_reg];

    // pointer and level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            level_next = level_reg + LVL_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            level_next = level_reg - LVL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            keys_mem[wr_ptr_reg]  <= push_keys;
            count_mem[wr_ptr_reg] <= push_count;
            info_mem[wr_ptr_reg]  <= push_info;
        end
    end

endmodule

// File: hdl/snp_back.sv
// snp_back: emits the head note one key per cycle, while note_stall allows, into the output register
// depends on snp_pkg; reads the head of snp_queue
module snp_back
    import snp_pkg::*;
#(
    parameter int MAX_CHORD = SNP_MAX_CHORD
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           head_valid,
    input  logic [MAX_CHORD*KEY_W-1:0]     head_keys,
    input  logic [$clog2(MAX_CHORD+1)-1:0] head_count,
    input  note_info_t                     head_info,
    output logic                           pop,
    output logic                           note_valid,
    input  logic                           note_stall,
    output out_item_t                      note_item
);

    localparam int CNT_W = $clog2(MAX_CHORD + 1);
    localparam int IDX_W = (MAX_CHORD > 1) ? $clog2(MAX_CHORD) : 1;

    logic [IDX_W-1:0] k_reg, k_next;
    logic             valid_reg, valid_next;
    out_item_t        item_reg;
    logic             load;
    logic             last;

    assign load = head_valid && (!valid_reg || !note_stall);
    assign last = ((CNT_W'(k_reg) + CNT_W'(1)) == head_count);
    assign pop  = load && last;

    assign note_valid = valid_reg;
    assign note_item  = item_reg;

    // key counter and output valid
    always_comb
    begin
        k_next     = k_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            k_next     = last ? '0 : k_reg + IDX_W'(1);
        end
        else if (!note_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg     <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            k_reg     <= k_next;
            valid_reg <= valid_next;
        end
    end

    // output item register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.key             <= head_keys[KEY_W*k_reg +: KEY_W];
            item_reg.duration        <= head_info.duration;
            item_reg.last_of_note    <= last;
            item_reg.chord_truncated <= head_info.truncated;
        end
    end

endmodule
